>>> hdl/bpl_pkg.sv
// shared constants and types for the blinn-phong lighting pipeline
package bpl_pkg;

    // default parameter values
    localparam int COMP_WIDTH_DEF = 16;
    localparam int EXP_BITS_DEF   = 8;

    // internal component width after reduction
    localparam int RED_W = 16;

    // cosine unit depth: operand product, root steps, quotient steps, output
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int COS_LAT    = 1 + SQRT_STEPS + DIV_STEPS + 1;

    localparam logic [16:0] ONE_Q16       = 17'd65536;
    localparam logic [17:0] INTENSITY_MAX = 18'd196608;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_AMBIENT_LIGHT    = 3'd0,
        REG_AMBIENT_REFLECT  = 3'd1,
        REG_DIFFUSE_LIGHT    = 3'd2,
        REG_DIFFUSE_REFLECT  = 3'd3,
        REG_SPECULAR_LIGHT   = 3'd4,
        REG_SPECULAR_REFLECT = 3'd5,
        REG_SHININESS        = 3'd6
    } reg_index_t;

endpackage

>>> hdl/bpl_cosine.sv
// pipelined clamped cosine: dot / floor(sqrt(|a|^2 |b|^2)) in q0.16
module bpl_cosine
    import bpl_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [31:0]              aa_in,
    input  logic [31:0]              bb_in,
    input  logic signed [33:0]       dot_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic [16:0]              q_out,
    output logic [SIDE_W-1:0]        side_out
);

    // root stages, index 0 is the operand product stage
    logic [63:0]       sq_x_reg    [SQRT_STEPS+1];
    logic [34:0]       sq_rem_reg  [SQRT_STEPS+1];
    logic [31:0]       sq_root_reg [SQRT_STEPS+1];
    logic [31:0]       sq_num_reg  [SQRT_STEPS+1];
    logic              sq_kill_reg [SQRT_STEPS+1];
    logic [SIDE_W-1:0] sq_side_reg [SQRT_STEPS+1];

    // quotient stages, index 0 is the unregistered start value
    logic [47:0]       dv_rem  [DIV_STEPS+1];
    logic [16:0]       dv_q    [DIV_STEPS+1];
    logic [31:0]       dv_den  [DIV_STEPS+1];
    logic              dv_kill [DIV_STEPS+1];
    logic [SIDE_W-1:0] dv_side [DIV_STEPS+1];

    logic [16:0]       q_reg;
    logic [SIDE_W-1:0] side_reg;
    logic              kill_next;

    // zero-length operand or non-positive dot gives a zero cosine
    assign kill_next = (aa_in == 32'd0) || (bb_in == 32'd0) || (dot_in <= 34'sd0);

    // operand product
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg[0]    <= aa_in * bb_in;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_num_reg[0]  <= kill_next ? 32'd0 : dot_in[31:0];
            sq_kill_reg[0] <= kill_next;
            sq_side_reg[0] <= side_in;
        end
    end

    // integer square root, one result bit per stage
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        logic [34:0] rem_t;
        logic [34:0] trial;
        logic        fits;

        assign rem_t = {sq_rem_reg[i][32:0], sq_x_reg[i][63:62]};
        assign trial = {1'b0, sq_root_reg[i], 2'b01};
        assign fits  = (rem_t >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_x_reg[i+1]    <= {sq_x_reg[i][61:0], 2'b00};
                sq_rem_reg[i+1]  <= fits ? (rem_t - trial) : rem_t;
                sq_root_reg[i+1] <= {sq_root_reg[i][30:0], fits};
                sq_num_reg[i+1]  <= sq_num_reg[i];
                sq_kill_reg[i+1] <= sq_kill_reg[i];
                sq_side_reg[i+1] <= sq_side_reg[i];
            end
        end
    end

    // division start value
    assign dv_rem[0]  = {sq_num_reg[SQRT_STEPS], 16'd0};
    assign dv_q[0]    = '0;
    assign dv_den[0]  = sq_root_reg[SQRT_STEPS];
    assign dv_kill[0] = sq_kill_reg[SQRT_STEPS];
    assign dv_side[0] = sq_side_reg[SQRT_STEPS];

    // restoring division, one quotient bit per stage from the top
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [47:0] sub;
        logic        fits;
        logic [47:0] rem_reg;
        logic [16:0] q_stage_reg;
        logic [31:0] den_reg;
        logic        kill_reg;
        logic [SIDE_W-1:0] side_stage_reg;

        assign sub  = {16'd0, dv_den[j]} << SH;
        assign fits = (dv_rem[j] >= sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg        <= fits ? (dv_rem[j] - sub) : dv_rem[j];
                q_stage_reg    <= {dv_q[j][15:0], fits};
                den_reg        <= dv_den[j];
                kill_reg       <= dv_kill[j];
                side_stage_reg <= dv_side[j];
            end
        end

        assign dv_rem[j+1]  = rem_reg;
        assign dv_q[j+1]    = q_stage_reg;
        assign dv_den[j+1]  = den_reg;
        assign dv_kill[j+1] = kill_reg;
        assign dv_side[j+1] = side_stage_reg;
    end

    // kill and limit to one
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dv_kill[DIV_STEPS]) begin
                q_reg <= '0;
            end else if (dv_q[DIV_STEPS] > ONE_Q16) begin
                q_reg <= ONE_Q16;
            end else begin
                q_reg <= dv_q[DIV_STEPS];
            end
            side_reg <= dv_side[DIV_STEPS];
        end
    end

    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

>>> hdl/bpl_power.sv
// pipelined integer power: one rounded q0.16 multiply per stage
module bpl_power
    import bpl_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int SIDE_W   = 1
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [EXP_BITS-1:0] expo,
    input  logic [16:0]         c_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic [16:0]         r_out,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int NP = (1 << EXP_BITS) - 1;

    logic [16:0]       r_reg    [NP];
    logic [16:0]       c_reg    [NP];
    logic [SIDE_W-1:0] side_reg [NP];

    for (genvar k = 0; k < NP; k++) begin : g_stage
        logic [16:0]       r_prev;
        logic [16:0]       c_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [33:0]       prod;
        logic [16:0]       r_round;

        if (k == 0) begin : g_first
            assign r_prev    = ONE_Q16;
            assign c_prev    = c_in;
            assign side_prev = side_in;
        end else begin : g_rest
            assign r_prev    = r_reg[k-1];
            assign c_prev    = c_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // round to nearest, result never exceeds one
        assign prod    = r_prev * c_prev + 34'd32768;
        assign r_round = prod[32:16];

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]    <= (EXP_BITS'(k) < expo) ? r_round : r_prev;
                c_reg[k]    <= c_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign r_out    = r_reg[NP-1];
    assign side_out = side_reg[NP-1];

endmodule

>>> hdl/blinn_phong_lighting.sv
// blinn-phong lighting pipeline, one sample per cycle
// throughput: one beat per cycle; the whole pipe holds when a result beat waits
// the depth comes from the 32-step square root, 17-step divider and one multiply
// per possible exponent step
// reset clears the valid line and loads the register defaults; no clearing pass
module blinn_phong_lighting
    import bpl_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int EXP_BITS   = EXP_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COMP_WIDTH-1:0] s_light_dir_x,
    input  logic signed [COMP_WIDTH-1:0] s_light_dir_y,
    input  logic signed [COMP_WIDTH-1:0] s_light_dir_z,
    input  logic signed [COMP_WIDTH-1:0] s_normal_x,
    input  logic signed [COMP_WIDTH-1:0] s_normal_y,
    input  logic signed [COMP_WIDTH-1:0] s_normal_z,
    input  logic signed [COMP_WIDTH-1:0] s_view_dir_x,
    input  logic signed [COMP_WIDTH-1:0] s_view_dir_y,
    input  logic signed [COMP_WIDTH-1:0] s_view_dir_z,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [17:0]                  m_intensity,
    output logic [16:0]                  m_diffuse_term,
    output logic [16:0]                  m_specular_term,
    output logic                         m_degenerate
);

    localparam int PRE_SHIFT = (COMP_WIDTH > RED_W) ? (COMP_WIDTH - RED_W) : 0;
    localparam int NP        = (1 << EXP_BITS) - 1;
    localparam int LAT       = 3 + COS_LAT + NP + 2;

    // configuration registers
    logic [15:0] ambient_light_reg, ambient_reflect_reg;
    logic [15:0] diffuse_light_reg, diffuse_reflect_reg;
    logic [15:0] specular_light_reg, specular_reflect_reg;
    logic [7:0]  shininess_reg;
    logic [31:0] amb_prod_reg, dif_prod_reg, spc_prod_reg;
    logic        cfg_wr;
    reg_index_t  cfg_idx;

    logic            en;
    logic [LAT-1:0]  valid_reg;

    logic signed [COMP_WIDTH-1:0] raw_s [3];
    logic signed [COMP_WIDTH-1:0] raw_m [3];
    logic signed [COMP_WIDTH-1:0] raw_v [3];

    logic signed [15:0] s_reg [3];
    logic signed [15:0] m_reg [3];
    logic signed [15:0] h_reg [3];

    logic signed [31:0] ss_reg [3];
    logic signed [31:0] mm_reg [3];
    logic signed [31:0] hh_reg [3];
    logic signed [31:0] sm_reg [3];
    logic signed [31:0] hm_reg [3];

    logic [31:0]        aa_reg, bb_reg, cc_reg;
    logic signed [33:0] dsm_reg, dhm_reg;
    logic               zero_d, zero_s;

    logic [16:0] diff_q, spec_q, spec_r;
    logic        diff_side, spec_side;
    logic [18:0] pw_side;

    logic [48:0] pd_reg, ps_reg;
    logic [16:0] diff_f_reg, spec_f_reg;
    logic        degen_f_reg;
    logic [50:0] sum;
    logic [20:0] tot;

    logic [17:0] intensity_reg;
    logic [16:0] diffuse_term_reg, specular_term_reg;
    logic        degenerate_reg;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ambient_light_reg    <= 16'd32768;
            ambient_reflect_reg  <= 16'd0;
            diffuse_light_reg    <= 16'd32768;
            diffuse_reflect_reg  <= 16'd32768;
            specular_light_reg   <= 16'd32768;
            specular_reflect_reg <= 16'd0;
            shininess_reg        <= 8'd1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_AMBIENT_LIGHT:    ambient_light_reg    <= pwdata[15:0];
                REG_AMBIENT_REFLECT:  ambient_reflect_reg  <= pwdata[15:0];
                REG_DIFFUSE_LIGHT:    diffuse_light_reg    <= pwdata[15:0];
                REG_DIFFUSE_REFLECT:  diffuse_reflect_reg  <= pwdata[15:0];
                REG_SPECULAR_LIGHT:   specular_light_reg   <= pwdata[15:0];
                REG_SPECULAR_REFLECT: specular_reflect_reg <= pwdata[15:0];
                REG_SHININESS:        shininess_reg        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_AMBIENT_LIGHT:    prdata = {16'd0, ambient_light_reg};
            REG_AMBIENT_REFLECT:  prdata = {16'd0, ambient_reflect_reg};
            REG_DIFFUSE_LIGHT:    prdata = {16'd0, diffuse_light_reg};
            REG_DIFFUSE_REFLECT:  prdata = {16'd0, diffuse_reflect_reg};
            REG_SPECULAR_LIGHT:   prdata = {16'd0, specular_light_reg};
            REG_SPECULAR_REFLECT: prdata = {16'd0, specular_reflect_reg};
            REG_SHININESS:        prdata = {24'd0, shininess_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // light times reflectance products, static while idle
    always_ff @(posedge aclk) begin
        amb_prod_reg <= ambient_light_reg * ambient_reflect_reg;
        dif_prod_reg <= diffuse_light_reg * diffuse_reflect_reg;
        spc_prod_reg <= specular_light_reg * specular_reflect_reg;
    end

    // global hold and valid line
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    assign raw_s[0] = s_light_dir_x;
    assign raw_s[1] = s_light_dir_y;
    assign raw_s[2] = s_light_dir_z;
    assign raw_m[0] = s_normal_x;
    assign raw_m[1] = s_normal_y;
    assign raw_m[2] = s_normal_z;
    assign raw_v[0] = s_view_dir_x;
    assign raw_v[1] = s_view_dir_y;
    assign raw_v[2] = s_view_dir_z;

    // reduce wide components toward zero, half vector, per-axis products
    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam logic [COMP_WIDTH:0] BIAS = (COMP_WIDTH+1)'((1 << PRE_SHIFT) - 1);
        logic signed [COMP_WIDTH:0] es, em, ev;
        logic signed [15:0]         rs, rm, rv;
        logic signed [16:0]         hsum;

        assign es = (raw_s[a] + $signed(raw_s[a][COMP_WIDTH-1] ? BIAS : '0)) >>> PRE_SHIFT;
        assign em = (raw_m[a] + $signed(raw_m[a][COMP_WIDTH-1] ? BIAS : '0)) >>> PRE_SHIFT;
        assign ev = (raw_v[a] + $signed(raw_v[a][COMP_WIDTH-1] ? BIAS : '0)) >>> PRE_SHIFT;
        assign rs = 16'(es);
        assign rm = 16'(em);
        assign rv = 16'(ev);
        assign hsum = 17'(rs) + 17'(rv);

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[a]  <= rs;
                m_reg[a]  <= rm;
                h_reg[a]  <= 16'(hsum >>> 1);
                ss_reg[a] <= s_reg[a] * s_reg[a];
                mm_reg[a] <= m_reg[a] * m_reg[a];
                hh_reg[a] <= h_reg[a] * h_reg[a];
                sm_reg[a] <= s_reg[a] * m_reg[a];
                hm_reg[a] <= h_reg[a] * m_reg[a];
            end
        end
    end

    // squared lengths and dot products
    always_ff @(posedge aclk) begin
        if (en) begin
            aa_reg  <= $unsigned(ss_reg[0]) + $unsigned(ss_reg[1]) + $unsigned(ss_reg[2]);
            bb_reg  <= $unsigned(mm_reg[0]) + $unsigned(mm_reg[1]) + $unsigned(mm_reg[2]);
            cc_reg  <= $unsigned(hh_reg[0]) + $unsigned(hh_reg[1]) + $unsigned(hh_reg[2]);
            dsm_reg <= 34'(sm_reg[0]) + 34'(sm_reg[1]) + 34'(sm_reg[2]);
            dhm_reg <= 34'(hm_reg[0]) + 34'(hm_reg[1]) + 34'(hm_reg[2]);
        end
    end

    assign zero_d = (aa_reg == 32'd0) || (bb_reg == 32'd0);
    assign zero_s = (cc_reg == 32'd0) || (bb_reg == 32'd0);

    bpl_cosine #(.SIDE_W(1)) u_diffuse (
        .aclk     (aclk),
        .en       (en),
        .aa_in    (aa_reg),
        .bb_in    (bb_reg),
        .dot_in   (dsm_reg),
        .side_in  (zero_d),
        .q_out    (diff_q),
        .side_out (diff_side)
    );

    bpl_cosine #(.SIDE_W(1)) u_specular (
        .aclk     (aclk),
        .en       (en),
        .aa_in    (cc_reg),
        .bb_in    (bb_reg),
        .dot_in   (dhm_reg),
        .side_in  (zero_s),
        .q_out    (spec_q),
        .side_out (spec_side)
    );

    bpl_power #(.EXP_BITS(EXP_BITS), .SIDE_W(19)) u_power (
        .aclk     (aclk),
        .en       (en),
        .expo     (EXP_BITS'(shininess_reg)),
        .c_in     (spec_q),
        .side_in  ({diff_q, diff_side, spec_side}),
        .r_out    (spec_r),
        .side_out (pw_side)
    );

    // scale diffuse and specular by the light products
    always_ff @(posedge aclk) begin
        if (en) begin
            diff_f_reg  <= pw_side[18:2];
            spec_f_reg  <= pw_side[0] ? 17'd0 : spec_r;
            pd_reg      <= dif_prod_reg * pw_side[18:2];
            ps_reg      <= spc_prod_reg * (pw_side[0] ? 17'd0 : spec_r);
            degen_f_reg <= pw_side[1] || pw_side[0];
        end
    end

    // sum, round to q.16 and saturate
    assign sum = {3'd0, amb_prod_reg, 16'd0} + {2'd0, pd_reg} + {2'd0, ps_reg}
               + (51'd1 << 29);
    assign tot = sum[50:30];

    always_ff @(posedge aclk) begin
        if (en) begin
            intensity_reg     <= (tot > 21'(INTENSITY_MAX)) ? INTENSITY_MAX : tot[17:0];
            diffuse_term_reg  <= diff_f_reg;
            specular_term_reg <= spec_f_reg;
            degenerate_reg    <= degen_f_reg;
        end
    end

    assign m_intensity     = intensity_reg;
    assign m_diffuse_term  = diffuse_term_reg;
    assign m_specular_term = specular_term_reg;
    assign m_degenerate    = degenerate_reg;

endmodule

>>> tb/blinn_phong_lighting_tb.sv
// self-checking testbench for the blinn-phong lighting pipeline
module blinn_phong_lighting_tb
    import bpl_pkg::*;
();

    localparam int LATENCY   = 320;
    localparam int MAX_CYCLE = 400000;

    typedef logic signed [15:0] comp_t;

    typedef struct packed {
        logic [17:0] intensity;
        logic [16:0] diffuse_term;
        logic [16:0] specular_term;
        logic        degenerate;
    } shade_t;

    typedef struct {
        comp_t lx, ly, lz, nx, ny, nz, vx, vy, vz;
    } sample_t;

    // shading predictor and store of expected results
    class shade_scoreboard;
        logic [15:0] amb_l, amb_r, dif_l, dif_r, spc_l, spc_r;
        logic [7:0]  shine;
        shade_t      pending[$];
        int          errors;

        function new();
            amb_l = 16'd32768; amb_r = 0; dif_l = 16'd32768; dif_r = 16'd32768;
            spc_l = 16'd32768; spc_r = 0; shine = 8'd1; errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] val);
            case (idx)
                REG_AMBIENT_LIGHT:    amb_l = val[15:0];
                REG_AMBIENT_REFLECT:  amb_r = val[15:0];
                REG_DIFFUSE_LIGHT:    dif_l = val[15:0];
                REG_DIFFUSE_REFLECT:  dif_r = val[15:0];
                REG_SPECULAR_LIGHT:   spc_l = val[15:0];
                REG_SPECULAR_REFLECT: spc_r = val[15:0];
                REG_SHININESS:        shine = val[7:0];
                default: ;
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // clamped cosine in q0.16; flags a zero-length operand
        function logic [16:0] cosine(longint a[3], longint b[3], output bit zero);
            longint aa, bb, d;
            longint unsigned den, q;
            aa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
            bb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
            d  = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
            zero = (aa == 0 || bb == 0);
            if (zero || d <= 0) return 0;
            den = isqrt(longint'(aa) * longint'(bb));
            if (den == 0) return ONE_Q16;
            q = (longint'(d) << 16) / den;
            return (q > 65536) ? ONE_Q16 : q[16:0];
        endfunction

        function void note_sample(sample_t x);
            longint s[3], m[3], h[3], t;
            longint unsigned r, sum, tot;
            bit zd, zs;
            logic [16:0] dif, cs;
            shade_t e;
            s = '{x.lx, x.ly, x.lz};
            m = '{x.nx, x.ny, x.nz};
            h = '{longint'(x.lx) + x.vx, longint'(x.ly) + x.vy, longint'(x.lz) + x.vz};
            // floor of half the sum
            for (int i = 0; i < 3; i++) begin
                t = h[i];
                h[i] = (t >= 0) ? t / 2 : -((1 - t) / 2);
            end
            dif = cosine(s, m, zd);
            cs  = cosine(h, m, zs);
            r = 65536;
            if (zs) r = 0;
            else for (int k = 0; k < shine && r != 0; k++) r = (r * cs + 32768) >> 16;
            sum = ((longint'(amb_l) * amb_r) << 16) + longint'(dif_l) * dif_r * dif
                + longint'(spc_l) * spc_r * r;
            tot = (sum + (64'd1 << 29)) >> 30;
            if (tot > 196608) tot = 196608;
            e.intensity = tot[17:0];
            e.diffuse_term = dif;
            e.specular_term = r[16:0];
            e.degenerate = zd | zs;
            pending.push_back(e);
        endfunction

        function void check_result(shade_t got);
            shade_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.intensity !== e.intensity) begin
                $error("intensity exp %0d got %0d", e.intensity, got.intensity); errors++;
            end
            if (got.diffuse_term !== e.diffuse_term) begin
                $error("diffuse_term exp %0d got %0d", e.diffuse_term, got.diffuse_term);
                errors++;
            end
            if (got.specular_term !== e.specular_term) begin
                $error("specular_term exp %0d got %0d", e.specular_term, got.specular_term);
                errors++;
            end
            if (got.degenerate !== e.degenerate) begin
                $error("degenerate exp %0d got %0d", e.degenerate, got.degenerate); errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic pready;
    logic s_valid = 0, s_ready;
    comp_t s_lx = 0, s_ly = 0, s_lz = 0, s_nx = 0, s_ny = 0, s_nz = 0;
    comp_t s_vx = 0, s_vy = 0, s_vz = 0;
    logic m_valid, m_ready = 0;
    logic [17:0] m_intensity;
    logic [16:0] m_diffuse_term, m_specular_term;
    logic m_degenerate;

    shade_scoreboard sb = new();
    int cycle = 0;

    always #1 aclk = ~aclk;

    blinn_phong_lighting dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_light_dir_x(s_lx), .s_light_dir_y(s_ly), .s_light_dir_z(s_lz),
        .s_normal_x(s_nx), .s_normal_y(s_ny), .s_normal_z(s_nz),
        .s_view_dir_x(s_vx), .s_view_dir_y(s_vy), .s_view_dir_z(s_vz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_intensity(m_intensity), .m_diffuse_term(m_diffuse_term),
        .m_specular_term(m_specular_term), .m_degenerate(m_degenerate)
    );

    // cycle limit
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("blinn_phong_lighting_tb NOT OK");
            $finish;
        end
    end

    // result side: check each accepted beat, then sometimes hold ready low for a random gap
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    sb.check_result('{m_intensity, m_diffuse_term, m_specular_term,
                                      m_degenerate});
                    gap = $urandom_range(0, 8);
                    if (gap != 0) begin
                        m_ready <= 0;
                        repeat (gap) @(posedge aclk);
                        m_ready <= 1;
                    end
                end else begin
                    m_ready <= 1;
                end
            end
        end
    end

    task automatic apb_write(reg_index_t idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, val);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    task automatic send(sample_t x, int gap);
        repeat (gap) @(posedge aclk);
        s_valid <= 1;
        s_lx <= x.lx; s_ly <= x.ly; s_lz <= x.lz;
        s_nx <= x.nx; s_ny <= x.ny; s_nz <= x.nz;
        s_vx <= x.vx; s_vy <= x.vy; s_vz <= x.vz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(x);
    endtask

    task automatic send_idle(sample_t x);
        int g;
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        if (g != 0) s_valid <= 0;
        send(x, g);
    endtask

    // drop valid at the last accepting edge, then wait for the results
    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic comp_t rnd_comp();
        case ($urandom_range(0, 5))
            0: return comp_t'($urandom_range(0, 65535));
            1: return comp_t'($signed($urandom_range(0, 6)) - 3);
            2: return 16'sh7fff;
            3: return -16'sh8000;
            default: return comp_t'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic sample_t rnd_sample();
        sample_t x;
        x.lx = rnd_comp(); x.ly = rnd_comp(); x.lz = rnd_comp();
        x.nx = rnd_comp(); x.ny = rnd_comp(); x.nz = rnd_comp();
        x.vx = rnd_comp(); x.vy = rnd_comp(); x.vz = rnd_comp();
        if ($urandom_range(0, 19) == 0) {x.lx, x.ly, x.lz} = '0;
        if ($urandom_range(0, 19) == 0) {x.nx, x.ny, x.nz} = '0;
        if ($urandom_range(0, 19) == 0) begin
            x.vx = -x.lx; x.vy = -x.ly; x.vz = -x.lz;
        end
        return x;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_idle(rnd_sample());
        drain();
    endtask

    // directed samples, then random phases under several register settings
    initial begin
        sample_t d[$];
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        apb_write(REG_AMBIENT_REFLECT, 32'd16384);
        apb_write(REG_SPECULAR_REFLECT, 32'd32768);
        apb_write(REG_SHININESS, 32'd8);
        d.push_back('{256, 0, 0, 256, 0, 0, 256, 0, 0});
        d.push_back('{256, 0, 0, -256, 0, 0, 256, 0, 0});
        d.push_back('{0, 0, 0, 0, 256, 0, 0, 256, 0});
        d.push_back('{256, 0, 0, 0, 0, 0, 0, 256, 0});
        d.push_back('{1, 0, 0, 0, 256, 0, 0, 0, 0});
        d.push_back('{256, 0, 0, 256, 0, 0, -256, 0, 0});
        d.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                      16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        d.push_back('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                      -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
        d.push_back('{16'sh7fff, -16'sh8000, 1, -1, 16'sh7fff, 0, -16'sh8000, 1, -1});
        d.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        d.push_back('{181, 181, 0, 0, 256, 0, 256, 0, 0});
        d.push_back('{-1, 0, 0, -1, 0, 0, 0, 0, 0});
        foreach (d[i]) send_idle(d[i]);
        drain();
        // shininess zero and everything at full scale
        apb_write(REG_SHININESS, 32'd0);
        apb_write(REG_AMBIENT_LIGHT, 32'hffff);
        apb_write(REG_AMBIENT_REFLECT, 32'hffff);
        apb_write(REG_DIFFUSE_LIGHT, 32'hffff);
        apb_write(REG_DIFFUSE_REFLECT, 32'hffff);
        apb_write(REG_SPECULAR_LIGHT, 32'hffff);
        apb_write(REG_SPECULAR_REFLECT, 32'hffff);
        foreach (d[i]) send_idle(d[i]);
        random_phase(100);
        // maximum exponent
        apb_write(REG_SHININESS, 32'd255);
        apb_write(REG_AMBIENT_LIGHT, 32'd0);
        apb_write(REG_DIFFUSE_LIGHT, 32'd32768);
        apb_write(REG_DIFFUSE_REFLECT, 32'd0);
        apb_write(REG_SPECULAR_REFLECT, 32'd32768);
        random_phase(150);
        // random settings
        for (int p = 0; p < 4; p++) begin
            apb_write(REG_AMBIENT_LIGHT, $urandom_range(0, 32768));
            apb_write(REG_AMBIENT_REFLECT, $urandom_range(0, 32768));
            apb_write(REG_DIFFUSE_LIGHT, $urandom_range(0, 32768));
            apb_write(REG_DIFFUSE_REFLECT, $urandom_range(0, 32768));
            apb_write(REG_SPECULAR_LIGHT, $urandom_range(0, 32768));
            apb_write(REG_SPECULAR_REFLECT, $urandom_range(0, 32768));
            apb_write(REG_SHININESS, $urandom_range(0, 255));
            random_phase(150);
        end
        if (sb.errors == 0) $display("blinn_phong_lighting_tb OK");
        else $display("blinn_phong_lighting_tb NOT OK");
        $finish;
    end
endmodule

>>> files.f
hdl/bpl_pkg.sv
hdl/bpl_cosine.sv
hdl/bpl_power.sv
hdl/blinn_phong_lighting.sv
tb/blinn_phong_lighting_tb.sv
